// ===== hw/rtl/csq_pkg.sv =====
// csq_pkg: shared types, constants and helpers of the coalescing status queue
// used by csq_ctrl, csq_dp and coalescing_status_queue; no dependencies
`default_nettype none

package csq_pkg;

  // queue geometry
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned SumW       = CntW + 1;

  // field widths
  localparam int unsigned OpW      = 2;
  localparam int unsigned TypeW    = 8;
  localparam int unsigned PayW     = 16;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned TimeoutW = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // stream beat widths, padded to whole bytes
  localparam int unsigned InBitsW  = OpW + TypeW + PayW + TimeW + 1;
  localparam int unsigned InDataW  = ((InBitsW + 7) / 8) * 8;
  localparam int unsigned OutBitsW = StatusW + 1 + 1 + TypeW + PayW + TimeW + 1 + CntW;
  localparam int unsigned OutDataW = ((OutBitsW + 7) / 8) * 8;

  // configuration reset values
  localparam logic [TypeW-1:0]    MinTypeRst = TypeW'(1);
  localparam logic [TypeW-1:0]    MetricsRst = TypeW'(2);
  localparam logic [TimeoutW-1:0] TimeoutRst = TimeoutW'(1000);

  typedef enum logic [OpW-1:0] {
    OpEnqueue   = 2'd0,
    OpPop       = 2'd1,
    OpWriteDone = 2'd2,
    OpQuery     = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 3'd0,
    StInvalid  = 3'd1,
    StStopped  = 3'd2,
    StOverflow = 3'd3,
    StEmpty    = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinType = 2'd0,
    CfgMetrics = 2'd1,
    CfgTimeout = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RdHead     = 2'd0,
    RdScan     = 2'd1,
    RdScanNext = 2'd2
  } rd_sel_e;

  typedef enum logic [3:0] {
    SIdle,
    SDispatch,
    SScanRd,
    SScanCmp,
    SAppend,
    SPopRd,
    SPopTake,
    SStallRd,
    SStallCalc
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    st_we;
    status_e st_code;
    logic    scan_inc;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    replace_wr;
    logic    append_wr;
    logic    overflow;
    logic    pop_take;
    logic    wdone;
    logic    out_load;
  } csq_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic lt_min;
    logic is_metrics;
    logic stopped;
    logic cnt_zero;
    logic cnt_full;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } csq_sts_t;

  // ring slot at an offset from the head
  function automatic logic [IdxW-1:0] slot_at(logic [IdxW-1:0] head, logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(head) + SumW'(off);
    if (sum >= SumW'(QueueDepth)) begin
      sum = sum - SumW'(QueueDepth);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/csq_ctrl.sv =====
// csq_ctrl: sequencer of the coalescing status queue
// depends on csq_pkg; drives csq_dp through csq_cmd_t and reads csq_sts_t
`default_nettype none

module csq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire csq_pkg::csq_sts_t sts_i,
  output csq_pkg::csq_cmd_t      cmd_o
);

  csq_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csq_pkg::SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csq_pkg::SIdle: begin
        if (in_valid_i) state_d = csq_pkg::SDispatch;
      end
      csq_pkg::SDispatch: begin
        unique case (sts_i.op)
          csq_pkg::OpEnqueue: begin
            if (sts_i.lt_min || sts_i.stopped) begin
              state_d = csq_pkg::SStallRd;
            end else if (sts_i.is_metrics && !sts_i.cnt_zero) begin
              state_d = csq_pkg::SScanRd;
            end else begin
              state_d = csq_pkg::SAppend;
            end
          end
          csq_pkg::OpPop: begin
            if (sts_i.stopped || sts_i.cnt_zero) begin
              state_d = csq_pkg::SStallRd;
            end else begin
              state_d = csq_pkg::SPopRd;
            end
          end
          default: state_d = csq_pkg::SStallRd;
        endcase
      end
      csq_pkg::SScanRd:  state_d = csq_pkg::SScanCmp;
      csq_pkg::SScanCmp: begin
        if (sts_i.scan_hit) begin
          state_d = csq_pkg::SStallRd;
        end else if (sts_i.scan_last) begin
          state_d = csq_pkg::SAppend;
        end
      end
      csq_pkg::SAppend:   state_d = csq_pkg::SStallRd;
      csq_pkg::SPopRd:    state_d = csq_pkg::SPopTake;
      csq_pkg::SPopTake:  state_d = csq_pkg::SStallRd;
      csq_pkg::SStallRd:  state_d = csq_pkg::SStallCalc;
      csq_pkg::SStallCalc: begin
        if (sts_i.out_free) state_d = csq_pkg::SIdle;
      end
      default: state_d = csq_pkg::SIdle;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.st_code = csq_pkg::StOk;
    cmd_o.rd_sel  = csq_pkg::RdHead;
    in_ready_o = 1'b0;
    unique case (state_q)
      csq_pkg::SIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      csq_pkg::SDispatch: begin
        unique case (sts_i.op)
          csq_pkg::OpEnqueue: begin
            if (sts_i.lt_min) begin
              cmd_o.st_we   = 1'b1;
              cmd_o.st_code = csq_pkg::StInvalid;
            end else if (sts_i.stopped) begin
              cmd_o.st_we   = 1'b1;
              cmd_o.st_code = csq_pkg::StStopped;
            end
          end
          csq_pkg::OpPop: begin
            if (sts_i.stopped) begin
              cmd_o.st_we   = 1'b1;
              cmd_o.st_code = csq_pkg::StStopped;
            end else if (sts_i.cnt_zero) begin
              cmd_o.st_we   = 1'b1;
              cmd_o.st_code = csq_pkg::StEmpty;
            end
          end
          csq_pkg::OpWriteDone: cmd_o.wdone = 1'b1;
          default: ;
        endcase
      end
      csq_pkg::SScanRd: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = csq_pkg::RdScan;
      end
      csq_pkg::SScanCmp: begin
        if (sts_i.scan_hit) begin
          cmd_o.replace_wr = 1'b1;
        end else if (!sts_i.scan_last) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_sel   = csq_pkg::RdScanNext;
          cmd_o.scan_inc = 1'b1;
        end
      end
      csq_pkg::SAppend: begin
        if (sts_i.cnt_full) begin
          cmd_o.overflow = 1'b1;
          cmd_o.st_we    = 1'b1;
          cmd_o.st_code  = csq_pkg::StOverflow;
        end else begin
          cmd_o.append_wr = 1'b1;
        end
      end
      csq_pkg::SPopRd: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = csq_pkg::RdHead;
      end
      csq_pkg::SPopTake: cmd_o.pop_take = 1'b1;
      csq_pkg::SStallRd: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = csq_pkg::RdHead;
      end
      csq_pkg::SStallCalc: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/csq_dp.sv =====
// csq_dp: datapath of the coalescing status queue: entry memory, ring pointers,
// configuration registers, stall check and result register; depends on csq_pkg
`default_nettype none

module csq_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [csq_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [csq_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  wire logic [csq_pkg::InDataW-1:0]      in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [csq_pkg::OutDataW-1:0]          out_data_o,
  input  wire csq_pkg::csq_cmd_t                cmd_i,
  output csq_pkg::csq_sts_t                     sts_o
);

  // configuration registers
  logic [csq_pkg::TypeW-1:0]    min_type_q;
  logic [csq_pkg::TypeW-1:0]    metrics_q;
  logic [csq_pkg::TimeoutW-1:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_type_q <= csq_pkg::MinTypeRst;
      metrics_q  <= csq_pkg::MetricsRst;
      timeout_q  <= csq_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      case (csq_pkg::cfg_idx_e'(cfg_idx_i))
        csq_pkg::CfgMinType: min_type_q <= cfg_wdata_i[csq_pkg::TypeW-1:0];
        csq_pkg::CfgMetrics: metrics_q  <= cfg_wdata_i[csq_pkg::TypeW-1:0];
        csq_pkg::CfgTimeout: timeout_q  <= cfg_wdata_i[csq_pkg::TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  // captured input beat
  logic [csq_pkg::OpW-1:0]   op_q;
  logic [csq_pkg::TypeW-1:0] type_q;
  logic [csq_pkg::PayW-1:0]  pay_q;
  logic [csq_pkg::TimeW-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_data_i[1:0];
      type_q <= in_data_i[9:2];
      pay_q  <= in_data_i[25:10];
      now_q  <= in_data_i[73:26];
    end
  end

  // ring control state
  logic [csq_pkg::IdxW-1:0]  head_q;
  logic [csq_pkg::CntW-1:0]  count_q;
  logic [csq_pkg::IdxW-1:0]  scan_q;
  logic                      writing_q;
  logic [csq_pkg::TimeW-1:0] since_q;
  logic                      stopped_q;

  // entry memory, one read port with registered data
  logic [csq_pkg::TypeW-1:0] type_mem [csq_pkg::QueueDepth];
  logic [csq_pkg::PayW-1:0]  pay_mem  [csq_pkg::QueueDepth];
  logic [csq_pkg::TimeW-1:0] time_mem [csq_pkg::QueueDepth];
  logic [csq_pkg::TypeW-1:0] rd_type_q;
  logic [csq_pkg::PayW-1:0]  rd_pay_q;
  logic [csq_pkg::TimeW-1:0] rd_time_q;
  logic [csq_pkg::IdxW-1:0]  rd_addr;
  logic [csq_pkg::IdxW-1:0]  wr_addr;
  logic [csq_pkg::CntW-1:0]  scan_off;

  assign scan_off = csq_pkg::CntW'(scan_q);

  // read address select
  always_comb begin
    case (cmd_i.rd_sel)
      csq_pkg::RdScan:     rd_addr = csq_pkg::slot_at(head_q, scan_off);
      csq_pkg::RdScanNext: rd_addr = csq_pkg::slot_at(head_q, scan_off + csq_pkg::CntW'(1));
      default:             rd_addr = head_q;
    endcase
  end

  // replace hits the scanned slot, append goes behind the tail
  assign wr_addr = cmd_i.replace_wr ? csq_pkg::slot_at(head_q, scan_off)
                                    : csq_pkg::slot_at(head_q, count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.append_wr) begin
      type_mem[wr_addr] <= type_q;
      time_mem[wr_addr] <= now_q;
    end
    if (cmd_i.append_wr || cmd_i.replace_wr) begin
      pay_mem[wr_addr] <= pay_q;
    end
    if (cmd_i.rd_en) begin
      rd_type_q <= type_mem[rd_addr];
      rd_pay_q  <= pay_mem[rd_addr];
      rd_time_q <= time_mem[rd_addr];
    end
  end

  // pointers, flags and scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      scan_q    <= '0;
      writing_q <= 1'b0;
      since_q   <= '0;
      stopped_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        scan_q <= '0;
        if (in_data_i[74]) stopped_q <= 1'b1;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + csq_pkg::IdxW'(1);
      end
      if (cmd_i.overflow) stopped_q <= 1'b1;
      if (cmd_i.append_wr) count_q <= count_q + csq_pkg::CntW'(1);
      if (cmd_i.pop_take) begin
        head_q    <= csq_pkg::slot_at(head_q, csq_pkg::CntW'(1));
        count_q   <= count_q - csq_pkg::CntW'(1);
        writing_q <= 1'b1;
        since_q   <= rd_time_q;
      end
      if (cmd_i.wdone) writing_q <= 1'b0;
    end
  end

  // per-item result fields
  csq_pkg::status_e          status_q;
  logic                      replaced_q;
  logic                      pop_valid_q;
  logic [csq_pkg::TypeW-1:0] pop_type_q;
  logic [csq_pkg::PayW-1:0]  pop_pay_q;
  logic [csq_pkg::TimeW-1:0] pop_time_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q    <= csq_pkg::StOk;
      replaced_q  <= 1'b0;
      pop_valid_q <= 1'b0;
      pop_type_q  <= '0;
      pop_pay_q   <= '0;
      pop_time_q  <= '0;
    end else begin
      if (cmd_i.st_we) status_q <= cmd_i.st_code;
      if (cmd_i.replace_wr) replaced_q <= 1'b1;
      if (cmd_i.pop_take) begin
        pop_valid_q <= 1'b1;
        pop_type_q  <= rd_type_q;
        pop_pay_q   <= rd_pay_q;
        pop_time_q  <= rd_time_q;
      end
    end
  end

  // age watchdog on the oldest pending time
  logic [csq_pkg::TimeW-1:0] oldest;
  logic [csq_pkg::TimeW-1:0] age;
  logic                      pending;
  logic                      stalled;

  assign oldest  = writing_q ? since_q : rd_time_q;
  assign pending = writing_q || (count_q != '0);
  assign age     = now_q - oldest;
  assign stalled = pending &&
                   ((now_q < oldest) || (age >= csq_pkg::TimeW'(timeout_q)));

  // output register
  logic                         out_valid_q;
  logic [csq_pkg::OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= csq_pkg::OutDataW'({count_q, stalled, pop_time_q, pop_pay_q,
                                        pop_type_q, pop_valid_q, replaced_q, status_q});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // status to the controller
  assign sts_o.op         = csq_pkg::op_e'(op_q);
  assign sts_o.lt_min     = type_q < min_type_q;
  assign sts_o.is_metrics = type_q == metrics_q;
  assign sts_o.stopped    = stopped_q;
  assign sts_o.cnt_zero   = count_q == '0;
  assign sts_o.cnt_full   = count_q >= csq_pkg::CntW'(csq_pkg::QueueDepth);
  assign sts_o.scan_hit   = rd_type_q == metrics_q;
  assign sts_o.scan_last  = (scan_off + csq_pkg::CntW'(1)) >= count_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== hw/rtl/coalescing_status_queue.sv =====
// coalescing_status_queue: top level of the coalescing status queue
// depends on csq_pkg, csq_ctrl and csq_dp
`default_nettype none

// Ring queue of outgoing status entries (type, payload reference, enqueue time)
// with metrics coalescing and an age watchdog. Each input beat carries one
// operation and yields exactly one result beat. Items are handled one at a
// time; each one, a stall query, write-done or rejected operation included,
// ends with a head read for the stall check before its result is registered.
// A metrics enqueue scans the queue from the head one entry per cycle and goes
// on to append when nothing matches. The result sits in an output register, so
// the next item is accepted while a result still waits. Configuration may be
// written only while the block is idle.
module coalescing_status_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [csq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [csq_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input stream
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // op, msg_type, payload_ref, now_ms, stop_asserted
  input  wire logic [csq_pkg::InDataW-1:0]   s_axis_tdata_i,
  // result stream
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // status, replaced, pop_valid, pop_type, pop_payload, pop_time_ms, stalled, occupancy
  output logic [csq_pkg::OutDataW-1:0]       m_axis_tdata_o
);

  csq_pkg::csq_cmd_t cmd;
  csq_pkg::csq_sts_t sts;

  // sequencer
  csq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  csq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire
